### rtl/core/cdbs_pkg.sv
// shared types and constants for the cell density bin scatter
// no dependencies
package cdbs_pkg;

  localparam int unsigned CELL_W   = 32;
  localparam int unsigned LANE_W   = 32;
  localparam int unsigned BIN_W    = 15;
  localparam int unsigned FLAT_W   = 30;
  localparam int unsigned SLAB_W   = 25;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned LOCAL_W  = 24;
  localparam int unsigned AREA_W   = 32;
  localparam int unsigned RATIO_W  = 32;
  localparam int unsigned SCALE_W  = 5;
  localparam int unsigned NUM_LANE = 8;
  localparam int unsigned SUM_W    = 94;
  localparam int unsigned IN_W     = 608;
  localparam int unsigned OUT_W    = 136;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BINS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_EN    = 3'd5;

  localparam logic [RATIO_W-1:0] RATIO_ONE  = 32'h0001_0000;
  localparam logic [5:0]         SHIFT_BASE = 6'd48;

  typedef struct packed {
    logic [BIN_W-1:0]   bins_x;
    logic [BIN_W-1:0]   bins_y;
    logic [SLAB_W-1:0]  slab_size;
    logic [OWNER_W-1:0] owner_count;
    logic [SCALE_W-1:0] scale_shift;
    logic               ratio_en;
  } cfg_t;

  // one bin pair to evaluate, or the end-of-cell token
  typedef struct packed {
    logic [CELL_W-1:0]  cell_id;
    logic [30:0]        ox;
    logic [30:0]        oy;
    logic [BIN_W-1:0]   bx;
    logic [BIN_W-1:0]   by;
    logic [RATIO_W-1:0] ratio;
    logic               is_end;
  } task_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_id;
    logic [FLAT_W-1:0]  flat;
    logic [OWNER_W-1:0] owner;
    logic [LOCAL_W-1:0] slab_ofs;
    logic [AREA_W-1:0]  area;
  } result_t;

endpackage

### rtl/core/cdbs_front.sv
// front end: takes a cell word, walks the overlap lanes and queues bin pairs
// depends on cdbs_pkg
module cdbs_front import cdbs_pkg::*; #(
  parameter int unsigned MAX_OVERLAP = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              q_full,
  output logic              q_push,
  output task_t             q_data
);

  localparam int unsigned JW = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;
  localparam logic [JW-1:0] LAST_LANE = JW'(MAX_OVERLAP - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_END  = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [CELL_W-1:0]  cell_r;
  logic [BIN_W-1:0]   bx0_r, by0_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [LANE_W-1:0]  ox_r [MAX_OVERLAP];
  logic [LANE_W-1:0]  oy_r [MAX_OVERLAP];
  logic [JW-1:0]      j_r, j_nxt, k_r, k_nxt;
  logic               sx_r, sx_nxt, sy_r, sy_nxt;

  logic [LANE_W-1:0]  lane_x [NUM_LANE];
  logic [LANE_W-1:0]  lane_y [NUM_LANE];
  logic [15:0]        lbx, lby;
  logic [BIN_W-1:0]   bx0_in, by0_in;
  logic               accept;

  logic [LANE_W-1:0]  ox, oy;
  logic               ox_pos, oy_pos, bx_ok, by_ok;
  logic [15:0]        bx_w, by_w;

  always_comb begin
    for (int i = 0; i < NUM_LANE; i++) begin
      lane_x[i] = in_tdata[64 + 32*i +: 32];
      lane_y[i] = in_tdata[320 + 32*i +: 32];
    end
  end

  assign lbx    = in_tdata[47:32];
  assign lby    = in_tdata[63:48];
  assign bx0_in = lbx[15] ? '0 : lbx[BIN_W-1:0];
  assign by0_in = lby[15] ? '0 : lby[BIN_W-1:0];

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign ox     = ox_r[j_r];
  assign oy     = oy_r[k_r];
  assign ox_pos = (ox != '0) && !ox[LANE_W-1];
  assign oy_pos = (oy != '0) && !oy[LANE_W-1];
  assign bx_w   = {1'b0, bx0_r} + 16'(j_r);
  assign by_w   = {1'b0, by0_r} + 16'(k_r);
  assign bx_ok  = bx_w < {1'b0, cfg.bins_x};
  assign by_ok  = by_w < {1'b0, cfg.bins_y};

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    q_push    = 1'b0;
    q_data.cell_id = cell_r;
    q_data.ox     = ox[30:0];
    q_data.oy     = oy[30:0];
    q_data.bx     = bx_w[BIN_W-1:0];
    q_data.by     = by_w[BIN_W-1:0];
    q_data.ratio  = ratio_r;
    q_data.is_end = 1'b0;

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          j_nxt  = '0;
          k_nxt  = '0;
          sx_nxt = 1'b0;
          sy_nxt = 1'b0;
          if ((bx0_in < cfg.bins_x) && (by0_in < cfg.bins_y)) begin
            state_nxt = F_SCAN;
          end else begin
            state_nxt = F_END;
          end
        end
      end
      F_SCAN: begin
        logic row_done;
        logic stall;
        row_done = 1'b0;
        stall    = 1'b0;
        if (!ox_pos) begin
          // two empty rows in a row end the cell
          if (sx_r) begin
            state_nxt = F_END;
          end else begin
            sx_nxt   = 1'b1;
            row_done = 1'b1;
          end
        end else begin
          sx_nxt = 1'b0;
          if (!bx_ok) begin
            row_done = 1'b1;
          end else if (!oy_pos) begin
            if (sy_r || (k_r == LAST_LANE)) begin
              row_done = 1'b1;
            end else begin
              sy_nxt = 1'b1;
              k_nxt  = k_r + 1'b1;
            end
          end else begin
            if (by_ok) begin
              if (q_full) begin
                stall = 1'b1;
              end else begin
                q_push = 1'b1;
              end
            end
            if (!stall) begin
              sy_nxt = 1'b0;
              if (k_r == LAST_LANE) begin
                row_done = 1'b1;
              end else begin
                k_nxt = k_r + 1'b1;
              end
            end
          end
        end
        if (row_done) begin
          k_nxt  = '0;
          sy_nxt = 1'b0;
          if (j_r == LAST_LANE) begin
            state_nxt = F_END;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      F_END: begin
        q_data.is_end = 1'b1;
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      j_r     <= '0;
      k_r     <= '0;
      sx_r    <= 1'b0;
      sy_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_r  <= in_tdata[31:0];
      bx0_r   <= bx0_in;
      by0_r   <= by0_in;
      ratio_r <= cfg.ratio_en ? in_tdata[607:576] : RATIO_ONE;
      for (int i = 0; i < MAX_OVERLAP; i++) begin
        ox_r[i] <= lane_x[i];
        oy_r[i] <= lane_y[i];
      end
    end
  end

endmodule

### rtl/core/cdbs_fifo.sv
// short queue of bin pairs between the front end and the back end
// depends on cdbs_pkg
module cdbs_fifo import cdbs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  task_t wr_data,
  input  logic  pop,
  output task_t rd_data,
  output logic  full,
  output logic  empty
);

  task_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wp_r, rp_r;
  logic [QUEUE_PTR_W:0]   cnt_r;
  logic                   do_push, do_pop;

  assign full    = (cnt_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

endmodule

### rtl/core/cdbs_div.sv
// restoring divider, one quotient bit per cycle, splits flat index by slab size
// depends on cdbs_pkg
module cdbs_div import cdbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FLAT_W-1:0] dividend,
  input  logic [SLAB_W-1:0] divisor,
  output logic              done,
  output logic [FLAT_W-1:0] quot,
  output logic [SLAB_W-1:0] rem
);

  localparam int unsigned CW = $clog2(FLAT_W);

  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [FLAT_W-1:0] q_r;
  logic [SLAB_W-1:0] rem_r, dvs_r;
  logic [SLAB_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, q_r[FLAT_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign done  = done_r;
  assign quot  = q_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(FLAT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[FLAT_W-2:0], fits};
      rem_r <= fits ? SLAB_W'(trial - {1'b0, dvs_r}) : trial[SLAB_W-1:0];
    end
  end

endmodule

### rtl/core/cdbs_back.sv
// back end: area product on one shared multiplier, flat index, owner split,
// filtering and the held-back result that carries the last marker
// depends on cdbs_pkg and cdbs_div
module cdbs_back import cdbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  task_t            q_data,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  typedef enum logic [9:0] {
    B_IDLE     = 10'b0000000001,
    B_MUL_P    = 10'b0000000010,
    B_MUL_LO   = 10'b0000000100,
    B_MUL_HI   = 10'b0000001000,
    B_MUL_F    = 10'b0000010000,
    B_SUM      = 10'b0000100000,
    B_SHIFT    = 10'b0001000000,
    B_DIV      = 10'b0010000000,
    B_EMIT_BIN = 10'b0100000000,
    B_EMIT_END = 10'b1000000000
  } bstate_t;

  bstate_t state_r, state_nxt;

  task_t             task_r;
  logic [61:0]       p_r, hi_r;
  logic [63:0]       lo_r;
  logic [FLAT_W-1:0] flat_r;
  logic [SUM_W-1:0]  sum_r, shifted;
  logic [AREA_W-1:0] area_r, area_w;
  logic [5:0]        shamt;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_y;

  result_t           pend_r, cand_r, cand_w;
  logic              pend_v_r;

  logic              out_valid_r, out_last_r, out_has_r;
  result_t           out_r;
  logic              can_push;

  logic              div_start, div_done;
  logic [FLAT_W-1:0] div_q;
  logic [SLAB_W-1:0] div_rem;

  cdbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (flat_r),
    .divisor  (cfg.slab_size),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // shared 32x32 multiplier, operands picked by step
  always_comb begin
    unique case (state_r)
      B_MUL_P:  begin mul_a = {1'b0, task_r.ox};   mul_b = {1'b0, task_r.oy}; end
      B_MUL_LO: begin mul_a = p_r[31:0];           mul_b = task_r.ratio; end
      B_MUL_HI: begin mul_a = {2'b0, p_r[61:32]};  mul_b = task_r.ratio; end
      B_MUL_F:  begin mul_a = 32'(task_r.bx);      mul_b = 32'(cfg.bins_y); end
      default:  begin mul_a = '0;                  mul_b = '0; end
    endcase
  end
  assign mul_y = mul_a * mul_b;

  assign shamt   = SHIFT_BASE - {1'b0, cfg.scale_shift};
  assign shifted = sum_r >> shamt;
  assign area_w  = (|shifted[SUM_W-1:AREA_W]) ? '1 : shifted[AREA_W-1:0];

  assign can_push = !out_valid_r || out_tready;

  always_comb begin
    cand_w.cell_id  = task_r.cell_id;
    cand_w.flat     = flat_r;
    cand_w.owner    = div_q[OWNER_W-1:0];
    cand_w.slab_ofs = div_rem[LOCAL_W-1:0];
    cand_w.area     = area_r;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = q_data.is_end ? B_EMIT_END : B_MUL_P;
        end
      end
      B_MUL_P:  state_nxt = B_MUL_LO;
      B_MUL_LO: state_nxt = B_MUL_HI;
      B_MUL_HI: state_nxt = B_MUL_F;
      B_MUL_F:  state_nxt = B_SUM;
      B_SUM:    state_nxt = B_SHIFT;
      B_SHIFT: begin
        if ((area_w == '0) || (cfg.slab_size == '0)) begin
          state_nxt = B_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (div_done) begin
          if (div_q >= FLAT_W'(cfg.owner_count)) state_nxt = B_IDLE;
          else if (pend_v_r)                     state_nxt = B_EMIT_BIN;
          else                                   state_nxt = B_IDLE;
        end
      end
      B_EMIT_BIN: if (can_push) state_nxt = B_IDLE;
      B_EMIT_END: if (can_push) state_nxt = B_IDLE;
      default:    state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DIV && div_done && div_q < FLAT_W'(cfg.owner_count) && !pend_v_r) begin
        pend_v_r <= 1'b1;
      end
      if (state_r == B_EMIT_END && can_push) begin
        pend_v_r <= 1'b0;
      end
      if ((state_r == B_EMIT_BIN || state_r == B_EMIT_END) && can_push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) task_r <= q_data;
    if (state_r == B_MUL_P)  p_r  <= mul_y[61:0];
    if (state_r == B_MUL_LO) lo_r <= mul_y;
    if (state_r == B_MUL_HI) hi_r <= mul_y[61:0];
    if (state_r == B_MUL_F)  flat_r <= mul_y[FLAT_W-1:0] + FLAT_W'(task_r.by);
    if (state_r == B_SUM)    sum_r <= SUM_W'(lo_r) + {hi_r, 32'b0};
    if (state_r == B_SHIFT)  area_r <= area_w;
    if (state_r == B_DIV && div_done) begin
      cand_r <= cand_w;
      if (!pend_v_r) pend_r <= cand_w;
    end
    if (state_r == B_EMIT_BIN && can_push) begin
      out_r      <= pend_r;
      out_last_r <= 1'b0;
      out_has_r  <= 1'b1;
      pend_r     <= cand_r;
    end
    if (state_r == B_EMIT_END && can_push) begin
      out_last_r <= 1'b1;
      if (pend_v_r) begin
        out_r     <= pend_r;
        out_has_r <= 1'b1;
      end else begin
        // cell without bins gives one empty marker
        out_r     <= '{cell_id: task_r.cell_id, default: '0};
        out_has_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_has_r;
  assign out_tdata  = {out_r.area, out_r.slab_ofs, out_r.owner,
                       2'b00, out_r.flat, out_r.cell_id};

endmodule

### rtl/core/cell_density_bin_scatter.sv
// cell density bin scatter, top level
// a kept bin waits for the next kept bin or the cell end before it is sent
// the front end takes one cell at a time; the back end finishes one bin pair before it takes
// the next, in steps: pop, 4 multiply steps, sum, shift, divide and emit, where an owner drop
// skips the emit and a zero area ends after the shift
// reset: rst_n synchronous active low, clears control state and sets the config registers to defaults
module cell_density_bin_scatter import cdbs_pkg::*; #(
  parameter int unsigned MAX_OVERLAP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_id, low_bin_x, low_bin_y, overlap_x_01..67, overlap_y_01..67, area_ratio
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cell_out, bin_flat, owner_index, local_index, area_amount
  output logic [OUT_W-1:0]      out_tdata,
  // has_area
  output logic                  out_tuser,
  output logic                  out_tlast
);

  cfg_t  cfg_r;
  logic  q_push, q_pop, q_full, q_empty;
  task_t q_wr, q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bins_x      <= '0;
      cfg_r.bins_y      <= '0;
      cfg_r.slab_size   <= SLAB_W'(1024);
      cfg_r.owner_count <= '0;
      cfg_r.scale_shift <= SCALE_W'(16);
      cfg_r.ratio_en    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BINS_X:      cfg_r.bins_x      <= cfg_wdata[BIN_W-1:0];
        CFG_BINS_Y:      cfg_r.bins_y      <= cfg_wdata[BIN_W-1:0];
        CFG_SLAB_SIZE:   cfg_r.slab_size   <= cfg_wdata[SLAB_W-1:0];
        CFG_OWNER_COUNT: cfg_r.owner_count <= cfg_wdata[OWNER_W-1:0];
        CFG_SCALE_SHIFT: cfg_r.scale_shift <= cfg_wdata[SCALE_W-1:0];
        CFG_RATIO_EN:    cfg_r.ratio_en    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cdbs_front #(.MAX_OVERLAP(MAX_OVERLAP)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr)
  );

  cdbs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  cdbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/core/cdbs_checker.sv
// port-level checks for the cell density bin scatter, bound to the top level
// depends on cdbs_pkg
module cdbs_checker import cdbs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser,
  input logic             out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[135:32] == '0))
    else $error("empty marker not last or not cleared");

  a_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[135:104] != '0))
    else $error("zero area emitted as contribution");

endmodule

bind cell_density_bin_scatter cdbs_checker u_cdbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
